// File: hw/rtl/lobm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ---------------------------------------------------------------------------
package lobm_pkg;

  localparam int ORDER_SLOTS_DEF = 32;
  localparam int IN_TDATA_W      = 120;
  localparam int OUT_TDATA_W     = 168;

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_MARKET = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_FILL_WAIT,
    ST_FREE,
    ST_CANCEL,
    ST_STATUS,
    ST_STATUS_WAIT
  } state_t;

  // request held for the duration of one transaction
  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] order_id;
    logic [15:0] trader;
    logic        side;
    logic [31:0] price_ticks;
    logic [31:0] quantity;
  } req_t;

  // result item
  typedef struct packed {
    logic        last;
    logic        cancel_found;
    logic        book_full;
    logic        rested;
    logic [31:0] remaining_quantity;
    logic [31:0] fill_quantity;
    logic [31:0] fill_price;
    logic [31:0] seller_order_id;
    logic [31:0] buyer_order_id;
    logic        kind;
  } res_t;

endpackage

// File: hw/rtl/lobm_cmp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lobm_cmp
// Shared compare unit: judges one slot against the request and current best.
// ---------------------------------------------------------------------------
module lobm_cmp (
  input  logic        slot_valid,
  input  logic        slot_side,
  input  logic [15:0] slot_trader,
  input  logic [31:0] slot_price,
  input  logic [31:0] slot_age,
  input  logic        req_side,
  input  logic [15:0] req_trader,
  input  logic        any_price,
  input  logic [31:0] limit,
  input  logic        have_best,
  input  logic [31:0] best_price,
  input  logic [31:0] best_age,
  output logic        take
);
  logic eligible;
  logic better;

  // eligibility then price-time priority
  always_comb begin
    eligible = slot_valid && (slot_side != req_side) && (slot_trader != req_trader);
    if (!any_price) begin
      if (!req_side && slot_price > limit) eligible = 1'b0;
      if (req_side && slot_price < limit) eligible = 1'b0;
    end
    if (slot_price != best_price) begin
      better = req_side ? (slot_price > best_price) : (slot_price < best_price);
    end else begin
      better = slot_age > best_age;
    end
    take = eligible && (!have_best || better);
  end
endmodule

// File: hw/rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time order book over a slot table, scanned by one compare unit.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transaction (limit, market, cancel or none).
//   out_* : zero or more fill items, then one status item with tlast high.
//   A request is taken only while the block is idle; in_tready stays low
//   until its status item has been taken on the output.
//   Each fill costs one scan of the table, one slot per cycle through the
//   shared compare unit. Placing a limit remainder adds a free-slot search
//   of up to ORDER_SLOTS slots; a cancel makes a buy pass, then a sell
//   pass over the table, and stops at the first match. With no fills a
//   limit request still makes one full scan before that search.
//   Each result item sits in an output register until out_tready; the
//   sequencer waits meanwhile, so a stalled receiver only delays the block.
//   Reset empties the book and clears the arrival counter.
// ---------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // order_id, trader, side, price_ticks, quantity (lowest first), 7 pad
  input  logic [lobm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                       in_tuser,  // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // buyer_order_id, seller_order_id, fill_price, fill_quantity,
  // remaining_quantity, rested, book_full, cancel_found (lowest first), 5 pad
  output logic [lobm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser, // kind
  output logic                             out_tlast
);
  import lobm_pkg::*;

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  state_t state_r, state_nxt;
  req_t   req_r;
  res_t   res_r;
  logic   out_valid_r;

  logic [ORDER_SLOTS-1:0] valid_r;
  logic                   side_r   [ORDER_SLOTS];
  logic [31:0]            price_r  [ORDER_SLOTS];
  logic [31:0]            oid_r    [ORDER_SLOTS];
  logic [15:0]            trader_r [ORDER_SLOTS];
  logic [31:0]            qty_r    [ORDER_SLOTS];
  logic [31:0]            arr_r    [ORDER_SLOTS];
  logic [31:0]            arrival_r;

  logic [IW-1:0] idx_r;
  logic          pass_r;     // cancel: 0 buy pass, 1 sell pass
  logic [CW-1:0] fills_r;
  logic          have_best_r;
  logic [IW-1:0] best_r;
  logic [31:0]   best_price_r, best_age_r;
  logic          take;
  logic [31:0]   tq;
  logic          last_idx;

  assign last_idx = (idx_r == IW'(ORDER_SLOTS - 1));

  lobm_cmp u_cmp (
    .slot_valid (valid_r[idx_r]),
    .slot_side  (side_r[idx_r]),
    .slot_trader(trader_r[idx_r]),
    .slot_price (price_r[idx_r]),
    .slot_age   (arrival_r - arr_r[idx_r]),
    .req_side   (req_r.side),
    .req_trader (req_r.trader),
    .any_price  (req_r.opcode == OP_MARKET),
    .limit      (req_r.price_ticks),
    .have_best  (have_best_r),
    .best_price (best_price_r),
    .best_age   (best_age_r),
    .take       (take)
  );

  assign tq = (req_r.quantity < qty_r[best_r]) ? req_r.quantity : qty_r[best_r];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {5'd0, res_r.cancel_found, res_r.book_full, res_r.rested,
                       res_r.remaining_quantity, res_r.fill_quantity,
                       res_r.fill_price, res_r.seller_order_id,
                       res_r.buyer_order_id};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        case (opcode_t'(in_tuser))
          OP_CANCEL: state_nxt = ST_CANCEL;
          OP_NONE:   state_nxt = ST_STATUS;
          default:   state_nxt = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        if (req_r.quantity == 32'd0 || fills_r == CW'(ORDER_SLOTS)) begin
          state_nxt = ST_FREE;
        end else if (last_idx) begin
          state_nxt = (have_best_r || take) ? ST_FILL : ST_FREE;
        end
      end
      ST_FILL:      state_nxt = ST_FILL_WAIT;
      ST_FILL_WAIT: if (!out_valid_r) state_nxt = ST_SCAN;
      ST_FREE: begin
        if (req_r.opcode != OP_LIMIT || req_r.quantity == 32'd0 ||
            !valid_r[idx_r] || last_idx) begin
          state_nxt = ST_STATUS;
        end
      end
      ST_CANCEL: if (last_idx && pass_r) state_nxt = ST_STATUS;
      ST_STATUS: state_nxt = ST_STATUS_WAIT;
      ST_STATUS_WAIT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_CANCEL && valid_r[idx_r] && side_r[idx_r] == pass_r &&
        oid_r[idx_r] == req_r.order_id) begin
      state_nxt = ST_STATUS;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // control, book and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      arrival_r   <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      pass_r      <= 1'b0;
      fills_r     <= '0;
      have_best_r <= 1'b0;
      res_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          req_r <= '{opcode: opcode_t'(in_tuser), order_id: in_tdata[31:0],
                     trader: in_tdata[47:32], side: in_tdata[48],
                     price_ticks: in_tdata[80:49], quantity: in_tdata[112:81]};
          res_r       <= '0;
          idx_r       <= '0;
          pass_r      <= 1'b0;
          fills_r     <= '0;
          have_best_r <= 1'b0;
        end
        ST_SCAN: begin
          if (take) begin
            have_best_r  <= 1'b1;
            best_r       <= idx_r;
            best_price_r <= price_r[idx_r];
            best_age_r   <= arrival_r - arr_r[idx_r];
          end
          if (req_r.quantity == 32'd0 || fills_r == CW'(ORDER_SLOTS) || last_idx) begin
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FILL: begin
          res_r <= '{last: 1'b0, cancel_found: 1'b0, book_full: 1'b0, rested: 1'b0,
                     remaining_quantity: '0, fill_quantity: tq,
                     fill_price: price_r[best_r],
                     seller_order_id: req_r.side ? req_r.order_id : oid_r[best_r],
                     buyer_order_id: req_r.side ? oid_r[best_r] : req_r.order_id,
                     kind: 1'b0};
          out_valid_r           <= 1'b1;
          req_r.quantity        <= req_r.quantity - tq;
          qty_r[best_r]         <= qty_r[best_r] - tq;
          if (qty_r[best_r] == tq) valid_r[best_r] <= 1'b0;
          fills_r     <= fills_r + 1'b1;
          have_best_r <= 1'b0;
          idx_r       <= '0;
        end
        ST_FILL_WAIT: if (out_tready) out_valid_r <= 1'b0;
        ST_FREE: begin
          if (req_r.opcode == OP_LIMIT && req_r.quantity != 32'd0) begin
            if (!valid_r[idx_r]) begin
              valid_r[idx_r]  <= 1'b1;
              side_r[idx_r]   <= req_r.side;
              price_r[idx_r]  <= req_r.price_ticks;
              oid_r[idx_r]    <= req_r.order_id;
              trader_r[idx_r] <= req_r.trader;
              qty_r[idx_r]    <= req_r.quantity;
              arr_r[idx_r]    <= arrival_r;
              arrival_r       <= arrival_r + 32'd1;
              res_r.rested    <= 1'b1;
            end else if (last_idx) begin
              res_r.book_full <= 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_CANCEL: begin
          if (valid_r[idx_r] && side_r[idx_r] == pass_r &&
              oid_r[idx_r] == req_r.order_id) begin
            valid_r[idx_r]     <= 1'b0;
            res_r.cancel_found <= 1'b1;
          end else if (last_idx) begin
            idx_r  <= '0;
            pass_r <= 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_STATUS: begin
          res_r <= '{last: 1'b1, cancel_found: res_r.cancel_found,
                     book_full: res_r.book_full, rested: res_r.rested,
                     remaining_quantity:
                       (req_r.opcode == OP_LIMIT || req_r.opcode == OP_MARKET) ?
                       req_r.quantity : '0,
                     fill_quantity: '0, fill_price: '0, seller_order_id: '0,
                     buyer_order_id: '0, kind: 1'b1};
          out_valid_r <= 1'b1;
        end
        ST_STATUS_WAIT: if (out_tready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

// File: hw/rtl/lobm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lobm_checker
// Port-level checks of the matcher, bound to the top level.
// ---------------------------------------------------------------------------
module lobm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lobm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);
  // a request is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input taken with result pending");

  // status items and only they carry tlast
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser)) else $error("tlast and kind differ");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // acceptance leaves the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);
